@@ rtl/utf8_to_utf16_decoder_assert.svh @@
// Assertion macros shared by the decoder RTL.
// Each macro checks an implication on the rising clock edge, outside reset.
`ifndef UTF8_TO_UTF16_DECODER_ASSERT_SVH
`define UTF8_TO_UTF16_DECODER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define U8U16_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication.
`define U8U16_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define U8U16_ASSERT_IMPLY(lbl, ante, cons)
`define U8U16_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ rtl/u8u16_pkg.sv @@
package u8u16_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned UnitW    = 16;
  localparam int unsigned PendW    = 2;
  localparam int unsigned PartialW = 10;
  localparam int unsigned Low6W    = 6;

  // Lead byte classification.
  localparam logic [ByteW-1:0] LEAD3_MASK = 8'hF0;
  localparam logic [ByteW-1:0] LEAD3_CODE = 8'hE0;
  localparam logic [ByteW-1:0] LEAD2_MASK = 8'hE0;
  localparam logic [ByteW-1:0] LEAD2_CODE = 8'hC0;
  localparam logic [ByteW-1:0] LEAD3_BITS = 8'h0F;
  localparam logic [ByteW-1:0] LEAD2_BITS = 8'h1F;
  localparam logic [ByteW-1:0] CONT_BITS  = 8'h3F;
  localparam logic [ByteW-1:0] ASCII_BITS = 8'h7F;
  localparam logic [ByteW-1:0] TERM_BYTE  = 8'h00;

  // Following-byte counts.
  localparam logic [PendW-1:0] PEND_NONE = 2'd0;
  localparam logic [PendW-1:0] PEND_ONE  = 2'd1;
  localparam logic [PendW-1:0] PEND_TWO  = 2'd2;
  localparam logic [PendW-1:0] PEND_BAD  = 2'd3;

  typedef struct packed {
    logic [PendW-1:0]    pend;
    logic [PartialW-1:0] partial;
  } u8u16_state_t;

  typedef struct packed {
    logic             emit;
    logic [UnitW-1:0] code_unit;
  } u8u16_result_t;

endpackage

@@ rtl/u8u16_stream_if.sv @@
// Byte request channel into the decoder.
interface u8u16_byte_if;
  logic                         valid;
  logic                         ready;
  logic [u8u16_pkg::ByteW-1:0]  data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// Code unit request channel out of the decoder.
interface u8u16_unit_if;
  logic                         valid;
  logic                         ready;
  logic [u8u16_pkg::UnitW-1:0]  code_unit;

  modport source (output valid, output code_unit, input ready);
  modport sink   (input valid, input code_unit, output ready);
endinterface

@@ rtl/u8u16_core.sv @@
module u8u16_core (
  input  logic [u8u16_pkg::ByteW-1:0] data_byte_i,
  input  u8u16_pkg::u8u16_state_t     state_i,
  output u8u16_pkg::u8u16_state_t     state_o,
  output u8u16_pkg::u8u16_result_t    result_o
);
  import u8u16_pkg::*;

  logic [Low6W-1:0] low6;
  logic [ByteW-1:0] lead3_bits;
  logic [ByteW-1:0] lead2_bits;
  logic [ByteW-1:0] ascii_bits;

  assign low6       = Low6W'(data_byte_i & CONT_BITS);
  assign lead3_bits = data_byte_i & LEAD3_BITS;
  assign lead2_bits = data_byte_i & LEAD2_BITS;
  assign ascii_bits = data_byte_i & ASCII_BITS;

  // Decode one byte against the current sequence state.
  always_comb begin
    state_o            = state_i;
    result_o.emit      = 1'b0;
    result_o.code_unit = '0;
    if (data_byte_i == TERM_BYTE) begin
      // The terminator drops any partial sequence.
      state_o.pend    = PEND_NONE;
      state_o.partial = '0;
    end else if (state_i.pend == PEND_ONE) begin
      // Last following byte completes the code unit.
      result_o.emit      = 1'b1;
      result_o.code_unit = {state_i.partial, low6};
      state_o.pend       = PEND_NONE;
      state_o.partial    = '0;
    end else if (state_i.pend != PEND_NONE) begin
      // Middle byte of a three-byte sequence; a count of three is counted down by one as well.
      state_o.partial = {state_i.partial[3:0], low6};
      state_o.pend    = state_i.pend - PEND_ONE;
    end else if ((data_byte_i & LEAD3_MASK) == LEAD3_CODE) begin
      state_o.partial = PartialW'(lead3_bits);
      state_o.pend    = PEND_TWO;
    end else if ((data_byte_i & LEAD2_MASK) == LEAD2_CODE) begin
      state_o.partial = PartialW'(lead2_bits);
      state_o.pend    = PEND_ONE;
    end else begin
      // Any other byte stands alone with its top bit cleared.
      result_o.emit      = 1'b1;
      result_o.code_unit = UnitW'(ascii_bits);
    end
  end

endmodule

@@ rtl/utf8_to_utf16_decoder.sv @@
// UTF-8 to UTF-16 decoder. Each request on in_i carries one byte of a UTF-8
// string; a request on out_o carries a 16-bit code unit whenever a two- or
// three-byte sequence completes, or a lone byte (any other lead byte, masked
// to seven bits) is seen. Following bytes are not checked. A zero byte ends
// the string, produces nothing and drops any partial sequence. The block
// takes one byte per clock while out_o is not stalled, and the code unit
// appears in the cycle after its last byte is accepted; the rate rests on
// the update of the sequence state register, and the output register lets
// a new byte enter while the previous code unit is still being taken.
module utf8_to_utf16_decoder (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  u8u16_byte_if.sink           in_i,
  u8u16_unit_if.source         out_o
);
  import u8u16_pkg::*;

  `include "utf8_to_utf16_decoder_assert.svh"

  u8u16_state_t     state_q, state_d;
  u8u16_result_t    result;
  logic             out_vld_q, out_vld_d;
  logic [UnitW-1:0] unit_q, unit_d;
  logic             in_acc;

  // Accept a byte whenever the output register is free or being emptied.
  assign in_i.ready = !out_vld_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;

  u8u16_core u_core (
    .data_byte_i (in_i.data_byte),
    .state_i     (state_q),
    .state_o     (state_d),
    .result_o    (result)
  );

  // Output register control.
  always_comb begin
    out_vld_d = out_vld_q;
    unit_d    = unit_q;
    if (in_acc) begin
      out_vld_d = result.emit;
      if (result.emit) begin
        unit_d = result.code_unit;
      end
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      if (in_acc) begin
        state_q <= state_d;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    unit_q <= unit_d;
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.code_unit = unit_q;

  `U8U16_ASSERT_IMPLY(a_pend_range, 1'b1, state_q.pend != PEND_BAD)
  `U8U16_ASSERT_IMPLY(a_partial_narrow, state_q.pend == PEND_TWO, state_q.partial[9:4] == 6'd0)
  `U8U16_ASSERT_NEXT(a_term_clears, in_acc && (in_i.data_byte == TERM_BYTE), (state_q.pend == PEND_NONE) && (state_q.partial == '0) && !out_vld_q)
  `U8U16_ASSERT_NEXT(a_lead3_starts, in_acc && (state_q.pend == PEND_NONE) && ((in_i.data_byte & LEAD3_MASK) == LEAD3_CODE), state_q.pend == PEND_TWO)
  `U8U16_ASSERT_IMPLY(a_out_from_accept, $rose(out_vld_q), $past(in_acc))

endmodule

@@ test/tb_utf8_to_utf16_decoder.sv @@
module tb_utf8_to_utf16_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import u8u16_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni;

  u8u16_byte_if byte_req ();
  u8u16_unit_if unit_req ();

  utf8_to_utf16_decoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_req),
    .out_o  (unit_req)
  );

  // Bytes waiting to be offered, and code units the decoder still owes us.
  logic [ByteW-1:0] utf8_bytes[$];
  logic [UnitW-1:0] expected_units[$];

  // Idle rates in percent, plus a receiver hold flag used for the hold-off phase.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        recv_hold     = 1'b0;
  int unsigned err_count     = 0;

  // Decoder state as we expect it to be.
  logic [PendW-1:0]    seq_pend    = PEND_NONE;
  logic [PartialW-1:0] seq_partial = '0;

  always #10 clk_i = ~clk_i;

  task automatic flag_error(input string msg);
    err_count++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  // Advance the expected decoder state by one byte; returns 1 when a code
  // unit comes out.
  function automatic bit decode_byte(input logic [ByteW-1:0] b,
                                     output logic [UnitW-1:0] unit);
    logic [ByteW-1:0] low6;
    unit = '0;
    // A terminator drops whatever sequence was in progress.
    if (b == TERM_BYTE) begin
      seq_pend    = PEND_NONE;
      seq_partial = '0;
      return 1'b0;
    end
    // Following bytes contribute their low six bits, unchecked.
    if (seq_pend != PEND_NONE) begin
      low6 = b & CONT_BITS;
      if (seq_pend == PEND_ONE) begin
        unit        = {seq_partial, low6[Low6W-1:0]};
        seq_pend    = PEND_NONE;
        seq_partial = '0;
        return 1'b1;
      end
      seq_partial = {seq_partial[3:0], low6[Low6W-1:0]};
      seq_pend    = seq_pend - 1'b1;
      return 1'b0;
    end
    if ((b & LEAD3_MASK) == LEAD3_CODE) begin
      seq_partial = PartialW'(b & LEAD3_BITS);
      seq_pend    = PEND_TWO;
      return 1'b0;
    end
    if ((b & LEAD2_MASK) == LEAD2_CODE) begin
      seq_partial = PartialW'(b & LEAD2_BITS);
      seq_pend    = PEND_ONE;
      return 1'b0;
    end
    // Everything else stands alone, masked to seven bits.
    unit = UnitW'(b & ASCII_BITS);
    return 1'b1;
  endfunction

  // Byte driver: holds a request until it is taken, then offers the next.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_req.valid     <= 1'b0;
      byte_req.data_byte <= '0;
    end else if (!byte_req.valid || byte_req.ready) begin
      if (utf8_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        byte_req.valid     <= 1'b1;
        byte_req.data_byte <= utf8_bytes.pop_front();
      end else begin
        byte_req.valid     <= 1'b0;
        byte_req.data_byte <= ByteW'($urandom);
      end
    end
  end

  // Code unit receiver with random back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_req.ready <= 1'b0;
    end else begin
      unit_req.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: predict on every accepted byte, then check every accepted unit.
  always @(posedge clk_i) begin
    logic [UnitW-1:0] unit;
    logic [UnitW-1:0] want;
    if (rst_ni) begin
      if (byte_req.valid && byte_req.ready) begin
        if (decode_byte(byte_req.data_byte, unit)) expected_units.push_back(unit);
      end
      if (unit_req.valid && unit_req.ready) begin
        if (expected_units.size() == 0) begin
          flag_error($sformatf("code unit 0x%04h arrived with none expected",
                               unit_req.code_unit));
        end else begin
          want = expected_units.pop_front();
          if (unit_req.code_unit !== want) begin
            flag_error($sformatf("code_unit 0x%04h, expected 0x%04h",
                                 unit_req.code_unit, want));
          end
        end
      end
    end
  end

  function automatic logic [ByteW-1:0] cont_byte();
    return {2'b10, 6'($urandom)};
  endfunction

  // Queue roughly n bytes of text: mostly well-formed characters with random
  // payload, plus terminators, random noise and broken sequences.
  task automatic queue_text(input int n);
    int sent;
    int kind;
    sent = 0;
    while (sent < n) begin
      kind = $urandom_range(99);
      if (kind < 30) begin
        utf8_bytes.push_back(ByteW'($urandom_range(8'h7F, 8'h01)));
        sent += 1;
      end else if (kind < 55) begin
        utf8_bytes.push_back({3'b110, 5'($urandom)});
        utf8_bytes.push_back(cont_byte());
        sent += 2;
      end else if (kind < 80) begin
        utf8_bytes.push_back({4'b1110, 4'($urandom)});
        utf8_bytes.push_back(cont_byte());
        utf8_bytes.push_back(cont_byte());
        sent += 3;
      end else if (kind < 85) begin
        utf8_bytes.push_back(TERM_BYTE);
        sent += 1;
      end else if (kind < 93) begin
        utf8_bytes.push_back(ByteW'($urandom));
        sent += 1;
      end else begin
        // A lead byte cut short by a terminator or followed by any byte.
        if ($urandom_range(1)) utf8_bytes.push_back({4'b1110, 4'($urandom)});
        else utf8_bytes.push_back({3'b110, 5'($urandom)});
        utf8_bytes.push_back($urandom_range(1) ? TERM_BYTE : ByteW'($urandom));
        sent += 2;
      end
    end
  endtask

  // Wait until every byte has been taken and every code unit has come back, or until the cycle limit is reached.
  task automatic wait_drained();
    int cycles;
    cycles = 0;
    while ((utf8_bytes.size() != 0 || byte_req.valid || expected_units.size() != 0)
           && cycles < 50000) begin
      @(posedge clk_i);
      cycles++;
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a terminator, then lone bytes at the edges of each class.
    utf8_bytes = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hBF, 8'hF0, 8'hFF};
    // Smallest and largest two- and three-byte sequences.
    utf8_bytes.push_back(8'hC0); utf8_bytes.push_back(8'h80);
    utf8_bytes.push_back(8'hDF); utf8_bytes.push_back(8'hBF);
    utf8_bytes.push_back(8'hE0); utf8_bytes.push_back(8'h80); utf8_bytes.push_back(8'h80);
    utf8_bytes.push_back(8'hEF); utf8_bytes.push_back(8'hBF); utf8_bytes.push_back(8'hBF);
    // A terminator abandons a partial sequence; the next byte starts clean.
    utf8_bytes.push_back(8'hE2); utf8_bytes.push_back(TERM_BYTE);
    utf8_bytes.push_back(8'h41);
    // Following bytes are taken whatever their top bits.
    utf8_bytes.push_back(8'hC3); utf8_bytes.push_back(8'hFF);
    utf8_bytes.push_back(8'hE5); utf8_bytes.push_back(8'h41); utf8_bytes.push_back(8'hC2);
    wait_drained();

    // Sender mostly busy, receiver mostly stalled.
    send_idle_pct <= 36;
    recv_idle_pct <= 86;
    @(posedge clk_i);
    queue_text(650);
    wait_drained();

    // Sender mostly idle, receiver mostly ready; pause mid-way for a full drain.
    send_idle_pct <= 86;
    recv_idle_pct <= 36;
    @(posedge clk_i);
    queue_text(325);
    wait_drained();
    queue_text(325);
    wait_drained();

    // No idling, but first a long receiver hold-off while bytes keep coming.
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    recv_hold     <= 1'b1;
    @(posedge clk_i);
    queue_text(650);
    // The hold-off is timed by its own process.
    fork
      begin
        repeat (300) @(posedge clk_i);
        recv_hold <= 1'b0;
      end
    join_none
    wait_drained();

    repeat (20) @(posedge clk_i);
    if (expected_units.size() != 0) begin
      flag_error($sformatf("%0d code units never arrived", expected_units.size()));
    end
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Hard limit on run time.
  initial begin
    #8_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
